// ----- hdl/stk_pkg.sv -----
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants for the source tokenizer
// Transaction structs, scanner mode codes, token kinds, character codes and
// the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

    // Counter widths
    localparam int OFFSET_WIDTH = 24;
    localparam int LINE_WIDTH   = 20;
    localparam int LENGTH_WIDTH = 16;
    localparam int KIND_WIDTH   = 5;

    // Identifier prefix kept for keyword matching
    localparam int PREFIX_DEPTH = 5;
    localparam int PREFIX_IDX_W = $clog2(PREFIX_DEPTH);
    localparam int KW_LEN_W     = $clog2(PREFIX_DEPTH + 1);
    localparam int NUM_KEYWORDS = 22;

    // Result queue (depth must be a power of two)
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Scanner modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    // Token kinds
    localparam logic [KIND_WIDTH-1:0] KIND_IDENT         = 5'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_NUMBER        = 5'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_ERROR         = 5'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_FIRST_KEYWORD = 5'd3;

    // Character codes
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    // Element 0 is the first byte of the identifier
    typedef logic [0:PREFIX_DEPTH-1][7:0] prefix_t;

    typedef struct packed {
        logic [KW_LEN_W-1:0] len;
        prefix_t             text;
    } keyword_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]   token_kind;
        logic [OFFSET_WIDTH-1:0] start_offset;
        logic [LENGTH_WIDTH-1:0] token_length;
        logic [LINE_WIDTH-1:0]   start_line;
        logic [LINE_WIDTH-1:0]   start_column;
        logic                    last_of_run;
    } tok_t;

    // Up to two tokens produced by one source byte
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } push_t;

    function automatic keyword_t kw_entry(input logic [KIND_WIDTH-1:0] idx);
        keyword_t kw;
        kw = '0;
        unique case (idx)
            5'd0:    kw = '{len: 3'd2, text: {"fn",    24'h0}};
            5'd1:    kw = '{len: 3'd2, text: {"if",    24'h0}};
            5'd2:    kw = '{len: 3'd3, text: {"let",   16'h0}};
            5'd3:    kw = '{len: 3'd3, text: {"var",   16'h0}};
            5'd4:    kw = '{len: 3'd4, text: {"else",   8'h0}};
            5'd5:    kw = '{len: 3'd3, text: {"for",   16'h0}};
            5'd6:    kw = '{len: 3'd3, text: {"mut",   16'h0}};
            5'd7:    kw = '{len: 3'd3, text: {"pub",   16'h0}};
            5'd8:    kw = '{len: 3'd3, text: {"use",   16'h0}};
            5'd9:    kw = '{len: 3'd4, text: {"enum",   8'h0}};
            5'd10:   kw = '{len: 3'd4, text: {"impl",   8'h0}};
            5'd11:   kw = '{len: 3'd4, text: {"true",   8'h0}};
            5'd12:   kw = '{len: 3'd4, text: {"self",   8'h0}};
            5'd13:   kw = '{len: 3'd4, text: {"type",   8'h0}};
            5'd14:   kw = '{len: 3'd4, text: {"with",   8'h0}};
            5'd15:   kw = '{len: 3'd4, text: {"elif",   8'h0}};
            5'd16:   kw = '{len: 3'd4, text: {"null",   8'h0}};
            5'd17:   kw = '{len: 3'd5, text: "match"};
            5'd18:   kw = '{len: 3'd5, text: "while"};
            5'd19:   kw = '{len: 3'd5, text: "trait"};
            5'd20:   kw = '{len: 3'd5, text: "async"};
            5'd21:   kw = '{len: 3'd5, text: "await"};
            default: kw = '0;
        endcase
        return kw;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/stk_kwmatch.sv -----
// ----------------------------------------------------------------------------
// stk_kwmatch: exact keyword match
// Compares an identifier prefix and length against the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_kwmatch (
    input  wire stk_pkg::prefix_t                     prefix,
    input  wire logic [stk_pkg::LENGTH_WIDTH-1:0]     len,
    output logic      [stk_pkg::KIND_WIDTH-1:0]       kind
);

    logic [stk_pkg::NUM_KEYWORDS-1:0] hit;
    stk_pkg::keyword_t                kw [stk_pkg::NUM_KEYWORDS];

    // One comparator per keyword; only the bytes inside the length count
    always_comb
    begin
        for (int k = 0; k < stk_pkg::NUM_KEYWORDS; k++)
        begin
            kw[k]  = stk_pkg::kw_entry(stk_pkg::KIND_WIDTH'(k));
            hit[k] = (len == stk_pkg::LENGTH_WIDTH'(kw[k].len));
            for (int i = 0; i < stk_pkg::PREFIX_DEPTH; i++)
            begin
                if ((stk_pkg::KW_LEN_W'(i) < kw[k].len) && (prefix[i] != kw[k].text[i]))
                begin
                    hit[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        kind = stk_pkg::KIND_IDENT;
        for (int k = stk_pkg::NUM_KEYWORDS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                kind = stk_pkg::KIND_FIRST_KEYWORD + stk_pkg::KIND_WIDTH'(k);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stk_scan.sv -----
// ----------------------------------------------------------------------------
// stk_scan: byte register, scanner state and token formation
// Registers one source byte, then classifies it, updates the position
// counters and the open token, and hands up to two tokens to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_scan (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    src_valid,
    output logic                   src_stall,
    input  wire stk_pkg::in_item_t src_data,
    input  wire                    room,
    output stk_pkg::push_t         push
);

    logic                                in_vld_reg;
    logic                                in_vld_next;
    stk_pkg::in_item_t                   in_data_reg;

    logic [1:0]                          mode_reg;
    logic [1:0]                          mode_next;
    logic [stk_pkg::OFFSET_WIDTH-1:0]    pos_reg;
    logic [stk_pkg::OFFSET_WIDTH-1:0]    pos_next;
    logic [stk_pkg::LINE_WIDTH-1:0]      line_reg;
    logic [stk_pkg::LINE_WIDTH-1:0]      line_next;
    logic [stk_pkg::LINE_WIDTH-1:0]      col_reg;
    logic [stk_pkg::LINE_WIDTH-1:0]      col_next;

    logic [stk_pkg::OFFSET_WIDTH-1:0]    start_off_reg;
    logic [stk_pkg::OFFSET_WIDTH-1:0]    start_off_next;
    logic [stk_pkg::LINE_WIDTH-1:0]      start_line_reg;
    logic [stk_pkg::LINE_WIDTH-1:0]      start_line_next;
    logic [stk_pkg::LINE_WIDTH-1:0]      start_col_reg;
    logic [stk_pkg::LINE_WIDTH-1:0]      start_col_next;
    logic [stk_pkg::LENGTH_WIDTH-1:0]    len_reg;
    logic [stk_pkg::LENGTH_WIDTH-1:0]    len_next;
    stk_pkg::prefix_t                    prefix_reg;
    stk_pkg::prefix_t                    prefix_next;

    logic [7:0]                          b;
    logic                                eos;
    logic                                proc;
    logic                                is_alpha;
    logic                                is_digit;
    logic                                is_space;
    logic                                ident_char;
    logic                                open_ident;
    logic                                open_num;
    logic                                cont;
    logic                                start_id;
    logic                                start_num;
    logic                                close_a;
    logic                                err;
    logic                                close_z;
    logic [1:0]                          mode_mid;
    logic [stk_pkg::KIND_WIDTH-1:0]      kw_kind_a;
    logic [stk_pkg::KIND_WIDTH-1:0]      kw_kind_z;
    stk_pkg::tok_t                       tok_a;
    stk_pkg::tok_t                       tok_e;
    stk_pkg::tok_t                       tok_z;

    assign b   = in_data_reg.byte_value;
    assign eos = in_data_reg.end_of_source;

    assign proc        = in_vld_reg && room;
    assign src_stall   = in_vld_reg && !room;
    assign in_vld_next = (src_valid && !src_stall) ? 1'b1 : (proc ? 1'b0 : in_vld_reg);

    // Byte classes, C locale
    assign is_alpha = ((b >= stk_pkg::CH_LOWER_A) && (b <= stk_pkg::CH_LOWER_Z)) ||
                      ((b >= stk_pkg::CH_UPPER_A) && (b <= stk_pkg::CH_UPPER_Z));
    assign is_digit = (b >= stk_pkg::CH_DIGIT_0) && (b <= stk_pkg::CH_DIGIT_9);
    assign is_space = (b == stk_pkg::CH_SPACE) ||
                      ((b >= stk_pkg::CH_TAB) && (b <= stk_pkg::CH_CR));
    assign ident_char = is_alpha || is_digit || (b == stk_pkg::CH_UNDERSCORE);

    // An unused mode code behaves as idle
    assign open_ident = (mode_reg == stk_pkg::MODE_IDENT);
    assign open_num   = (mode_reg == stk_pkg::MODE_NUMBER);
    assign cont       = (open_ident && ident_char) ||
                        (open_num && (is_digit || (b == stk_pkg::CH_DOT)));
    assign close_a    = !cont && (open_ident || open_num);
    assign start_id   = !cont && (is_alpha || (b == stk_pkg::CH_UNDERSCORE));
    assign start_num  = !cont && is_digit;
    assign err        = !cont && !is_space && !start_id && !start_num;

    // Open token after this byte, before the end flag
    always_comb
    begin
        mode_mid        = mode_reg;
        len_next        = len_reg;
        prefix_next     = prefix_reg;
        start_off_next  = start_off_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        if (cont)
        begin
            if (len_reg != '1)
            begin
                len_next = len_reg + 1'b1;
            end
            if (open_ident && (len_reg < stk_pkg::LENGTH_WIDTH'(stk_pkg::PREFIX_DEPTH)))
            begin
                prefix_next[len_reg[stk_pkg::PREFIX_IDX_W-1:0]] = b;
            end
        end
        else
        begin
            mode_mid        = start_id  ? stk_pkg::MODE_IDENT  :
                              start_num ? stk_pkg::MODE_NUMBER : stk_pkg::MODE_IDLE;
            len_next        = stk_pkg::LENGTH_WIDTH'(1);
            start_off_next  = pos_reg;
            start_line_next = line_reg;
            start_col_next  = col_reg;
            if (start_id)
            begin
                prefix_next[0] = b;
            end
        end
    end

    assign close_z = eos && (mode_mid != stk_pkg::MODE_IDLE);

    stk_kwmatch u_kw_a (
        .prefix (prefix_reg),
        .len    (len_reg),
        .kind   (kw_kind_a)
    );

    stk_kwmatch u_kw_z (
        .prefix (prefix_next),
        .len    (len_next),
        .kind   (kw_kind_z)
    );

    always_comb
    begin
        tok_a.token_kind   = open_ident ? kw_kind_a : stk_pkg::KIND_NUMBER;
        tok_a.start_offset = start_off_reg;
        tok_a.token_length = len_reg;
        tok_a.start_line   = start_line_reg;
        tok_a.start_column = start_col_reg;
        tok_a.last_of_run  = 1'b0;

        tok_e.token_kind   = stk_pkg::KIND_ERROR;
        tok_e.start_offset = pos_reg;
        tok_e.token_length = stk_pkg::LENGTH_WIDTH'(1);
        tok_e.start_line   = line_reg;
        tok_e.start_column = col_reg;
        tok_e.last_of_run  = 1'b0;

        tok_z.token_kind   = (mode_mid == stk_pkg::MODE_IDENT) ? kw_kind_z
                                                               : stk_pkg::KIND_NUMBER;
        tok_z.start_offset = start_off_next;
        tok_z.token_length = len_next;
        tok_z.start_line   = start_line_next;
        tok_z.start_column = start_col_next;
        tok_z.last_of_run  = 1'b0;
    end

    // Order: closed token, then error byte or end-flag flush
    always_comb
    begin
        push.tok0 = close_a ? tok_a : (err ? tok_e : tok_z);
        push.tok1 = err ? tok_e : tok_z;
        if (proc)
        begin
            push.count = 2'(close_a) + 2'(err) + 2'(close_z);
        end
        else
        begin
            push.count = 2'd0;
        end
        push.tok0.last_of_run = (push.count == 2'd1);
        push.tok1.last_of_run = 1'b1;
    end

    // Position counters and mode
    always_comb
    begin
        mode_next = eos ? stk_pkg::MODE_IDLE : mode_mid;
        pos_next  = (pos_reg != '1) ? pos_reg + 1'b1 : pos_reg;
        if (b == stk_pkg::CH_NEWLINE)
        begin
            line_next = (line_reg != '1) ? line_reg + 1'b1 : line_reg;
            col_next  = stk_pkg::LINE_WIDTH'(1);
        end
        else
        begin
            line_next = line_reg;
            col_next  = (col_reg != '1) ? col_reg + 1'b1 : col_reg;
        end
        if (eos)
        begin
            pos_next  = '0;
            line_next = stk_pkg::LINE_WIDTH'(1);
            col_next  = stk_pkg::LINE_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= stk_pkg::MODE_IDLE;
            pos_reg    <= '0;
            line_reg   <= stk_pkg::LINE_WIDTH'(1);
            col_reg    <= stk_pkg::LINE_WIDTH'(1);
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (proc)
            begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                line_reg <= line_next;
                col_reg  <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            in_data_reg <= src_data;
        end
        if (proc)
        begin
            start_off_reg  <= start_off_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            len_reg        <= len_next;
            prefix_reg     <= prefix_next;
        end
    end

    // End flag returns the counters to their reset values
    a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && eos) |=> ((mode_reg == stk_pkg::MODE_IDLE) && (pos_reg == '0) &&
                           (line_reg == stk_pkg::LINE_WIDTH'(1)) &&
                           (col_reg == stk_pkg::LINE_WIDTH'(1))))
        else $error("scanner state not restarted after end of source");

endmodule

`default_nettype wire

// ----- hdl/stk_outq.sv -----
// ----------------------------------------------------------------------------
// stk_outq: token result queue
// Small register queue that takes up to two tokens per cycle and returns
// one per cycle on the output channel while tok_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_outq (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire stk_pkg::push_t  push,
    output logic                 room,
    output logic                 tok_valid,
    input  wire                  tok_stall,
    output stk_pkg::tok_t        tok_data
);

    stk_pkg::tok_t                     q_reg [stk_pkg::OUTQ_DEPTH];
    logic [stk_pkg::OUTQ_PTR_W-1:0]    wptr_reg;
    logic [stk_pkg::OUTQ_PTR_W-1:0]    wptr_next;
    logic [stk_pkg::OUTQ_PTR_W-1:0]    rptr_reg;
    logic [stk_pkg::OUTQ_PTR_W-1:0]    rptr_next;
    logic [stk_pkg::OUTQ_CNT_W-1:0]    count_reg;
    logic [stk_pkg::OUTQ_CNT_W-1:0]    count_next;
    logic [stk_pkg::OUTQ_PTR_W-1:0]    wptr_second;
    logic                              pop;

    assign tok_valid = (count_reg != '0);
    assign tok_data  = q_reg[rptr_reg];
    assign pop       = tok_valid && !tok_stall;

    // Room for a worst-case pair, judged before this cycle's pop
    assign room = (count_reg <= stk_pkg::OUTQ_CNT_W'(stk_pkg::OUTQ_DEPTH - 2));

    assign wptr_second = wptr_reg + 1'b1;
    assign wptr_next   = wptr_reg + stk_pkg::OUTQ_PTR_W'(push.count);
    assign rptr_next   = rptr_reg + stk_pkg::OUTQ_PTR_W'(pop);
    assign count_next  = count_reg + stk_pkg::OUTQ_CNT_W'(push.count)
                                   - stk_pkg::OUTQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2)
        begin
            q_reg[wptr_second] <= push.tok1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stk_pkg::OUTQ_CNT_W'(stk_pkg::OUTQ_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |->
            (count_reg <= stk_pkg::OUTQ_CNT_W'(stk_pkg::OUTQ_DEPTH - 2)))
        else $error("tokens pushed without room in result queue");

endmodule

`default_nettype wire

// ----- hdl/source_tokenizer_keywords.sv -----
// A byte is scanned from the byte register and its tokens enter the result queue.
// Throughput: one source byte per cycle while src_stall is low; a byte may yield
// 0, 1 or 2 token transactions; the 4-entry result queue absorbs the second token
// of a pair, and src_stall rises only while fewer than two queue slots are free.
// Reset (rst_n low, async): queue empty, scanner idle, offset 0, line 1, column 1.
// ----------------------------------------------------------------------------
// source_tokenizer_keywords: streaming lexical scanner with keyword match
// Takes source bytes and emits zero-copy tokens (kind, start offset, length,
// start line and column). Identifiers up to five bytes are matched exactly
// against the keyword list when they close.
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer_keywords (
    input  wire                    clk,
    input  wire                    rst_n,

    // Source byte channel
    input  wire                    src_valid,
    output logic                   src_stall,
    input  wire stk_pkg::in_item_t src_data,

    // Token channel
    output logic                   tok_valid,
    input  wire                    tok_stall,
    output stk_pkg::tok_t          tok_data
);

    // Tokens formed from the registered byte, zero to two per cycle
    stk_pkg::push_t push;

    // Queue can take a full pair this cycle
    logic           room;

    // Scanner: byte register, classification, position counters, open token
    // and keyword matching. The byte register frees as soon as the byte is
    // scanned, so a new transaction is taken every cycle while room holds.
    stk_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .room      (room),
        .push      (push)
    );

    // Result queue: registered token outputs, decouples the two channels so
    // a stalled token transaction does not stop the scanner until fewer than two slots are free.
    stk_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

    // Input only stalls when the queue is nearly full, so tokens must be waiting
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> tok_valid)
        else $error("source stalled while no token is pending");

endmodule

`default_nettype wire
